>>> rtl/cpm2d_pkg.sv
// Shared constants and helper functions for the contact position manifold block.
`default_nettype none
package cpm2d_pkg;

  localparam int UFB = 14;
  localparam int UHALF = 1 << (UFB - 1);
  localparam int ISQ_BITS = 63;
  localparam int ISQ_STEPS = 32;
  localparam int QDIV_BITS = 46;

  localparam logic [1:0] KIND_CIRCLES = 2'd0;
  localparam logic [1:0] KIND_FACE_A  = 2'd1;
  localparam logic [1:0] KIND_FACE_B  = 2'd2;
  localparam logic [1:0] KIND_UNSET   = 2'd3;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/contact_position_manifold_2d.sv
// Top level of the 2D contact position manifold solver.
`default_nettype none
// One contact word in, one result word out, one word per cycle sustained while
// the output is not stalled. The pipe holds 84 register stages: four of
// transform and dot product, 32 of square root, one divide setup and 46 of
// divide for the circle normal, and one output register. The whole pipe
// freezes while out_stall holds a finished word.
module contact_position_manifold_2d import cpm2d_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [31:0] in_a_pos_x, in_a_pos_y,
  input  wire logic [31:0]        in_a_rotation,
  input  wire logic signed [31:0] in_b_pos_x, in_b_pos_y,
  input  wire logic [31:0]        in_b_rotation,
  input  wire logic signed [31:0] in_local_point_x, in_local_point_y,
  input  wire logic [31:0]        in_local_normal,
  input  wire logic signed [31:0] in_point_local_x, in_point_local_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_normal_x, out_normal_y,
  output logic signed [31:0]      out_point_x, out_point_y, out_separation,
  output logic                    out_valid_res
);
  logic adv;
  // advance unless a finished word waits
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  cpm2d_solve u_solve (
    .clk, .rst_n, .adv, .in_v(in_valid), .kind(in_action),
    .apx(in_a_pos_x), .apy(in_a_pos_y), .bpx(in_b_pos_x), .bpy(in_b_pos_y),
    .lpx(in_local_point_x), .lpy(in_local_point_y),
    .qpx(in_point_local_x), .qpy(in_point_local_y),
    .arot(in_a_rotation), .brot(in_b_rotation), .lnrm(in_local_normal),
    .o_v(out_valid), .o_nx(out_normal_x), .o_ny(out_normal_y),
    .o_px(out_point_x), .o_py(out_point_y), .o_sep(out_separation),
    .o_ok(out_valid_res)
  );

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_separation))
    else $error("result word changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
`endif
endmodule
`default_nettype wire

>>> rtl/cpm2d_solve.sv
// Pipelined datapath: transforms, circle normalization and face separation.
`default_nettype none
module cpm2d_solve import cpm2d_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_v,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] apx, apy, bpx, bpy, lpx, lpy, qpx, qpy,
  input  wire logic [31:0]        arot, brot, lnrm,
  output logic                    o_v,
  output logic signed [15:0]      o_nx, o_ny,
  output logic signed [31:0]      o_px, o_py, o_sep,
  output logic                    o_ok
);
  // Depth after the three front stages: 1 prescale, 32 root steps, 1 divide setup,
  // 46 divide steps.
  localparam int NS = 1 + ISQ_STEPS + 1 + QDIV_BITS;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [34:0] px, py;
    logic signed [15:0] nx, ny;
    logic signed [63:0] sep;
    logic [62:0] rem, root;
    logic [31:0] ax, ay;
    logic sgx, sgy, zero;
    logic [5:0] k;
    logic [QDIV_BITS-1:0] qx, qy;
    logic [QDIV_BITS:0] rx, ry;
    logic [31:0] len;
  } st_t;

  st_t s_r [NS];
  logic vl_r [NS];

  // Stage 0 products
  logic signed [15:0] oc, os, tc, ts, lnx, lny;
  logic signed [31:0] ownx, owny, othx, othy;
  logic fa;
  logic signed [49:0] m_r [10];
  logic signed [31:0] opx_r, opy_r, tpx_r, tpy_r;
  logic [1:0] k0_r;

  always_comb begin
    fa   = (kind != KIND_FACE_B);
    oc   = fa ? arot[31:16] : brot[31:16];
    os   = fa ? arot[15:0]  : brot[15:0];
    tc   = fa ? brot[31:16] : arot[31:16];
    ts   = fa ? brot[15:0]  : arot[15:0];
    ownx = fa ? apx : bpx;  owny = fa ? apy : bpy;
    othx = fa ? bpx : apx;  othy = fa ? bpy : apy;
    lnx  = lnrm[31:16];     lny  = lnrm[15:0];
  end

  // Stage A: all products
  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= 50'(oc * lpx);  m_r[1] <= 50'(os * lpy);
      m_r[2] <= 50'(os * lpx);  m_r[3] <= 50'(oc * lpy);
      m_r[4] <= 50'(tc * qpx);  m_r[5] <= 50'(ts * qpy);
      m_r[6] <= 50'(ts * qpx);  m_r[7] <= 50'(tc * qpy);
      m_r[8] <= 50'(oc * lnx - os * lny);
      m_r[9] <= 50'(os * lnx + oc * lny);
      opx_r <= ownx; opy_r <= owny; tpx_r <= othx; tpy_r <= othy;
      k0_r <= kind;
    end
  end

  // Stage B: world points and normal
  logic signed [34:0] plx_r, ply_r, clx_r, cly_r;
  logic signed [15:0] fnx_r, fny_r;
  logic [1:0] k1_r;
  logic signed [49:0] r0, r1, r2, r3, r4, r5;
  always_comb begin
    r0 = (m_r[0] - m_r[1] + 50'(UHALF)) >>> UFB;
    r1 = (m_r[2] + m_r[3] + 50'(UHALF)) >>> UFB;
    r2 = (m_r[4] - m_r[5] + 50'(UHALF)) >>> UFB;
    r3 = (m_r[6] + m_r[7] + 50'(UHALF)) >>> UFB;
    r4 = (m_r[8] + 50'(UHALF)) >>> UFB;
    r5 = (m_r[9] + 50'(UHALF)) >>> UFB;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      plx_r <= 35'(r0 + 50'(opx_r)); ply_r <= 35'(r1 + 50'(opy_r));
      clx_r <= 35'(r2 + 50'(tpx_r)); cly_r <= 35'(r3 + 50'(tpy_r));
      fnx_r <= sat16(36'(r4));       fny_r <= sat16(36'(r5));
      k1_r <= k0_r;
    end
  end

  // Stage C: differences, midpoint, dot products
  logic signed [35:0] dx, dy;
  logic signed [52:0] dpx_r, dpy_r;
  logic signed [35:0] dxr_r, dyr_r;
  logic signed [34:0] mx_r, my_r, cx_r, cy_r;
  logic signed [15:0] nx2_r, ny2_r;
  logic [1:0] k2_r;
  logic signed [35:0] sx, sy;
  always_comb begin
    dx = 36'(clx_r) - 36'(plx_r);
    dy = 36'(cly_r) - 36'(ply_r);
    sx = 36'(clx_r) + 36'(plx_r);
    sy = 36'(cly_r) + 36'(ply_r);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dpx_r <= 53'(dx * fnx_r); dpy_r <= 53'(dy * fny_r);
      dxr_r <= dx; dyr_r <= dy;
      mx_r <= 35'(sx >>> 1); my_r <= 35'(sy >>> 1);
      cx_r <= clx_r; cy_r <= cly_r;
      nx2_r <= fnx_r; ny2_r <= fny_r; k2_r <= k1_r;
    end
  end

  // Stage D: face separation, circle magnitudes and prescale
  logic signed [53:0] dsum;
  logic [35:0] amx, amy;
  logic [5:0] kk;
  logic [35:0] orv;
  st_t s0;
  always_comb begin
    dsum = 54'(dpx_r) + 54'(dpy_r) + 54'(UHALF);
    amx = dxr_r[35] ? 36'(-dxr_r) : 36'(dxr_r);
    amy = dyr_r[35] ? 36'(-dyr_r) : 36'(dyr_r);
    orv = amx | amy;
    kk = 6'd0;
    for (int i = 31; i < 36; i++)
      if (orv[i]) kk = 6'(i - 30);
  end

  always_comb begin
    st_t z;
    z = '0;
    z.kind = k2_r;
    if (k2_r == KIND_CIRCLES) begin
      z.px = mx_r; z.py = my_r;
    end else begin
      z.px = cx_r; z.py = cy_r;
    end
    z.nx = nx2_r; z.ny = ny2_r;
    z.sep = 64'(dsum >>> UFB);
    z.ax = 32'(amx >> kk); z.ay = 32'(amy >> kk);
    z.k = kk;
    z.sgx = dxr_r[35]; z.sgy = dyr_r[35];
    z.rem = 63'(z.ax) * 63'(z.ax) + 63'(z.ay) * 63'(z.ay);
    z.zero = (z.ax == 32'd0) && (z.ay == 32'd0);
    z.root = '0;
    s0 = z;
  end

  // Pipeline of root steps, then divide steps
  st_t nxt [NS];
  always_comb begin
    nxt[0] = s0;
    for (int j = 1; j < NS; j++) nxt[j] = s_r[j-1];
    // integer square root: one result bit per stage
    for (int j = 1; j <= ISQ_STEPS; j++) begin
      logic [62:0] rt, bit_v, tr;
      bit_v = 63'(1) << (2 * (ISQ_STEPS - j));
      rt = s_r[j-1].root;
      tr = rt + bit_v;
      if (s_r[j-1].rem >= tr) begin
        nxt[j].rem = s_r[j-1].rem - tr;
        nxt[j].root = (rt >> 1) + bit_v;
      end else begin
        nxt[j].root = rt >> 1;
      end
    end
    // set up dividends
    begin
      int j;
      j = ISQ_STEPS + 1;
      nxt[j].len = s_r[j-1].root[31:0];
      nxt[j].rx = '0; nxt[j].ry = '0;
      nxt[j].qx = (QDIV_BITS'(s_r[j-1].ax) << UFB) + QDIV_BITS'(s_r[j-1].root[31:1]);
      nxt[j].qy = (QDIV_BITS'(s_r[j-1].ay) << UFB) + QDIV_BITS'(s_r[j-1].root[31:1]);
    end
    // restoring divide: one quotient bit per stage, dividend shifts into remainder
    for (int j = ISQ_STEPS + 2; j < ISQ_STEPS + 2 + QDIV_BITS; j++) begin
      logic [QDIV_BITS:0] trx, tryy;
      trx  = {s_r[j-1].rx[QDIV_BITS-1:0], s_r[j-1].qx[QDIV_BITS-1]};
      tryy = {s_r[j-1].ry[QDIV_BITS-1:0], s_r[j-1].qy[QDIV_BITS-1]};
      nxt[j].qx = {s_r[j-1].qx[QDIV_BITS-2:0], 1'b0};
      nxt[j].qy = {s_r[j-1].qy[QDIV_BITS-2:0], 1'b0};
      if (trx >= (QDIV_BITS+1)'(s_r[j-1].len)) begin
        nxt[j].rx = trx - (QDIV_BITS+1)'(s_r[j-1].len); nxt[j].qx[0] = 1'b1;
      end else nxt[j].rx = trx;
      if (tryy >= (QDIV_BITS+1)'(s_r[j-1].len)) begin
        nxt[j].ry = tryy - (QDIV_BITS+1)'(s_r[j-1].len); nxt[j].qy[0] = 1'b1;
      end else nxt[j].ry = tryy;
    end
  end

  // Advance the pipeline; valid bits travel with the data
  logic [2:0] fv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      for (int j = 0; j < NS; j++) vl_r[j] <= 1'b0;
    end else if (adv) begin
      fv_r <= {fv_r[1:0], in_v};
      vl_r[0] <= fv_r[2];
      for (int j = 1; j < NS; j++) vl_r[j] <= vl_r[j-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) for (int j = 0; j < NS; j++) s_r[j] <= nxt[j];
  end

  // Final stage: pick results per kind
  st_t f;
  logic [QDIV_BITS-1:0] qxm, qym;
  logic signed [15:0] cnx, cny;
  logic signed [63:0] csep;
  always_comb begin
    f = s_r[NS-1];
    qxm = f.qx; qym = f.qy;
    cnx = (qxm > QDIV_BITS'(32767)) ? (f.sgx ? 16'sh8000 : 16'sh7fff)
        : (f.sgx ? -$signed(qxm[15:0]) : $signed(qxm[15:0]));
    if (f.sgx && qxm == QDIV_BITS'(32768)) cnx = 16'sh8000;
    cny = (qym > QDIV_BITS'(32767)) ? (f.sgy ? 16'sh8000 : 16'sh7fff)
        : (f.sgy ? -$signed(qym[15:0]) : $signed(qym[15:0]));
    if (f.sgy && qym == QDIV_BITS'(32768)) cny = 16'sh8000;
    csep = $signed(64'(f.len) << f.k);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) o_v <= 1'b0;
    else if (adv) o_v <= vl_r[NS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      o_ok <= (f.kind != KIND_UNSET);
      if (f.kind == KIND_CIRCLES) begin
        o_nx <= f.zero ? 16'sd0 : cnx;
        o_ny <= f.zero ? 16'sd0 : cny;
        o_sep <= f.zero ? 32'sd0 : sat32(csep);
        o_px <= sat32(64'(f.px)); o_py <= sat32(64'(f.py));
      end else if (f.kind == KIND_FACE_A || f.kind == KIND_FACE_B) begin
        o_nx <= (f.kind == KIND_FACE_B) ? sat16(-36'(f.nx)) : f.nx;
        o_ny <= (f.kind == KIND_FACE_B) ? sat16(-36'(f.ny)) : f.ny;
        o_sep <= sat32(f.sep);
        o_px <= sat32(64'(f.px)); o_py <= sat32(64'(f.py));
      end else begin
        o_nx <= '0; o_ny <= '0; o_sep <= '0; o_px <= '0; o_py <= '0;
      end
    end
  end
endmodule
`default_nettype wire
